// ===== src/ufmt_pkg.sv =====
// shared types, constants and the digit-to-character function of the ascii formatter
package ufmt_pkg;

  localparam int MAX_CHARS  = 24;
  localparam int VAL_W      = 32;
  localparam int NUM_DIGITS = 10;            // decimal digits of a 32-bit value
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int ND_W       = $clog2(NUM_DIGITS + 1);
  localparam int PW_W       = 5;
  localparam int CHAR_W     = 7;
  localparam int CIDX_W     = 8;
  localparam int CDATA_W    = 8;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_HEX_MODE   = 8'd0;
  localparam logic [CIDX_W-1:0] REG_UPPER_CASE = 8'd1;
  localparam logic [CIDX_W-1:0] REG_ZERO_PAD   = 8'd2;
  localparam logic [CIDX_W-1:0] REG_PAD_WIDTH  = 8'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;

  // configuration as seen by the datapath
  typedef struct packed {
    logic            hex_mode;
    logic            upper_case;
    logic            zero_pad;
    logic [PW_W-1:0] pad_width;
  } fmt_cfg_t;

  // result of one conversion, most significant digit in the top nibble
  typedef struct packed {
    logic             done;
    logic [DIG_W-1:0] digits;
  } conv_res_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d > 4'd9) begin
      digit_char = base + CHAR_W'(d - 4'd10);
    end else begin
      digit_char = CH_ZERO + CHAR_W'(d);
    end
  endfunction

endpackage

// ===== src/unsigned_to_ascii_formatter_core.sv =====
// top level of the unsigned to ascii text formatter
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata[31:0] value
//  out_    | out | out_tvalid/tready  | tdata[6:0] text_char, tlast last_char
//  cfg_    | in  | cfg_valid/ready    | cfg_index register, cfg_data value
//
// decimal: bit-serial bcd conversion after the accept, hex: a direct load of the value;
// then a digit load, leading zero removal down to one digit and a pad setup step, then
// one character per cycle as out_tready allows, up to 24 characters per number
// one number is in flight at a time: in_tready drops on accept and rises again once the
// finish strobe, registered with the last character, has cleared busy_r
// rst_n is synchronous, configuration resets to zero and is always ready; a stalled
// out_tready holds the output register and the emitter waits behind it
module unsigned_to_ascii_formatter_core import ufmt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VAL_W-1:0]   in_tdata,    // [31:0] value
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,   // [6:0] text_char, [7] zero
  output logic               out_tlast,   // last_char
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  fmt_cfg_t          cfg_r;
  logic              busy_r;
  logic              in_beat;
  logic              finish;
  conv_res_t         conv;
  logic [CHAR_W-1:0] out_char;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign in_beat   = in_tvalid && !busy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEX_MODE:   cfg_r.hex_mode   <= cfg_data[0];
        REG_UPPER_CASE: cfg_r.upper_case <= cfg_data[0];
        REG_ZERO_PAD:   cfg_r.zero_pad   <= cfg_data[0];
        REG_PAD_WIDTH:  cfg_r.pad_width  <= cfg_data[PW_W-1:0];
        default: ;
      endcase
    end
  end

  // busy from input beat until the last character is queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_beat) begin
      busy_r <= 1'b1;
    end else if (finish) begin
      busy_r <= 1'b0;
    end
  end

  ufmt_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_beat),
    .value    (in_tdata),
    .hex_mode (cfg_r.hex_mode),
    .res      (conv)
  );

  ufmt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .conv       (conv),
    .cfg        (cfg_r),
    .finish     (finish),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

// ===== src/ufmt_conv.sv =====
// bit-serial binary to bcd converter (shift and add three), hex values pass straight
module ufmt_conv import ufmt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] value,
  input  logic             hex_mode,
  output conv_res_t        res
);

  typedef enum logic {C_IDLE, C_RUN} cst_t;

  localparam int CNT_W = $clog2(VAL_W);

  cst_t             st_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0] bin_r;
  logic [DIG_W-1:0] bcd_r;
  logic             done_r;
  logic [DIG_W-1:0] adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  // sequencer and shift registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        C_IDLE: begin
          if (start) begin
            if (hex_mode) begin
              bcd_r  <= DIG_W'(value);
              done_r <= 1'b1;
            end else begin
              bcd_r <= '0;
              bin_r <= value;
              cnt_r <= CNT_W'(VAL_W - 1);
              st_r  <= C_RUN;
            end
          end
        end
        C_RUN: begin
          bcd_r <= {adj[DIG_W-2:0], bin_r[VAL_W-1]};
          bin_r <= {bin_r[VAL_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            done_r <= 1'b1;
            st_r   <= C_IDLE;
          end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign res.done   = done_r;
  assign res.digits = bcd_r;

endmodule

// ===== src/ufmt_emit.sv =====
// drops leading zero digits, then sends pad and digit characters one beat a cycle as out_tready allows
module ufmt_emit import ufmt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  conv_res_t         conv,
  input  fmt_cfg_t          cfg,
  output logic              finish,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  typedef enum logic [1:0] {E_IDLE, E_NORM, E_EMIT} est_t;

  est_t              st_r;
  logic [DIG_W-1:0]  dig_r;
  logic [ND_W-1:0]   nd_r;
  logic [PW_W-1:0]   pad_cnt_r;
  logic              vld_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic              fin_r;
  logic [PW_W-1:0]   width_sat;
  logic              slot_free;
  logic [3:0]        top_dig;

  assign width_sat = (cfg.pad_width > PW_W'(MAX_CHARS)) ? PW_W'(MAX_CHARS) : cfg.pad_width;
  assign slot_free = !vld_r || out_tready;
  assign top_dig   = dig_r[DIG_W-1 -: 4];

  // state, digit shifter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= E_IDLE;
      vld_r     <= 1'b0;
      fin_r     <= 1'b0;
      nd_r      <= '0;
      pad_cnt_r <= '0;
    end else begin
      fin_r <= 1'b0;
      if (vld_r && out_tready) begin
        vld_r <= 1'b0;
      end
      unique case (st_r)
        E_IDLE: begin
          if (conv.done) begin
            dig_r <= conv.digits;
            nd_r  <= ND_W'(NUM_DIGITS);
            st_r  <= E_NORM;
          end
        end
        E_NORM: begin
          if (nd_r > ND_W'(1) && top_dig == 4'd0) begin
            dig_r <= {dig_r[DIG_W-5:0], 4'd0};
            nd_r  <= nd_r - 1'b1;
          end else begin
            pad_cnt_r <= (width_sat > PW_W'(nd_r)) ? width_sat - PW_W'(nd_r) : '0;
            st_r      <= E_EMIT;
          end
        end
        E_EMIT: begin
          if (slot_free) begin
            vld_r <= 1'b1;
            if (pad_cnt_r != '0) begin
              char_r    <= cfg.zero_pad ? CH_ZERO : CH_SPACE;
              last_r    <= 1'b0;
              pad_cnt_r <= pad_cnt_r - 1'b1;
            end else begin
              char_r <= digit_char(top_dig, cfg.upper_case);
              last_r <= (nd_r == ND_W'(1));
              dig_r  <= {dig_r[DIG_W-5:0], 4'd0};
              nd_r   <= nd_r - 1'b1;
              if (nd_r == ND_W'(1)) begin
                fin_r <= 1'b1;
                st_r  <= E_IDLE;
              end
            end
          end
        end
        default: st_r <= E_IDLE;
      endcase
    end
  end

  assign finish     = fin_r;
  assign out_tvalid = vld_r;
  assign out_char   = char_r;
  assign out_last   = last_r;

  // a new conversion only arrives while the emitter is free
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    conv.done |-> st_r == E_IDLE)
    else $error("conversion result arrived while emitter busy");

  // digit count stays within the digit register while a number is in flight
  a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != E_IDLE |-> (nd_r != '0 && nd_r <= ND_W'(NUM_DIGITS)))
    else $error("digit count out of range");

  // pads plus digits never exceed the character limit
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == E_EMIT |-> (6'(pad_cnt_r) + 6'(nd_r)) <= 6'(MAX_CHARS))
    else $error("text longer than buffer");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the unsigned to ascii text formatter core
module testbench import ufmt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_VALUES = 470;
  localparam int DIR_ROWS     = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  // one character beat as it should leave the block
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  // one directed row: optional register setup, then one value
  typedef struct packed {
    logic               wr_cfg;
    logic [CDATA_W-1:0] hex_d;
    logic [CDATA_W-1:0] up_d;
    logic [CDATA_W-1:0] zp_d;
    logic [CDATA_W-1:0] pw_d;
    logic [VAL_W-1:0]   value;
  } dir_row_t;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [VAL_W-1:0]   in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;
  logic               out_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  fmt_cfg_t   fmt;                // shadow of the format registers
  text_beat_t pending_chars [$];  // characters still owed by the block
  int         mismatches = 0;
  bit         hold_req   = 1'b0;
  bit         hold_done  = 1'b0;

  // directed rows, hand-typed text where it is obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'd0},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'hFFFF_FFFF},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'd9},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'd1000000000},
    '{1'b1, 8'd1,   8'd1,   8'd0,   8'd0,   32'hFFFF_FFFF},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'h89AB_CDEF},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'd0},
    '{1'b1, 8'd1,   8'd0,   8'd0,   8'd0,   32'hFFFF_FFFF},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'h0000_FACE},
    '{1'b1, 8'd0,   8'd0,   8'd1,   8'd24,  32'd0},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'hFFFF_FFFF},
    '{1'b1, 8'h02,  8'h03,  8'h00,  8'hFF,  32'd7},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'hFFFF_FFFF},
    '{1'b1, 8'd0,   8'd0,   8'd0,   8'd1,   32'd0},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'd5},
    '{1'b1, 8'd0,   8'd0,   8'd1,   8'd10,  32'hFFFF_FFFF},
    '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   32'd42},
    '{1'b1, 8'd0,   8'd0,   8'd0,   8'd11,  32'hFFFF_FFFF},
    '{1'b1, 8'd1,   8'd1,   8'd1,   8'd8,   32'd1},
    '{1'b1, 8'd1,   8'd0,   8'd0,   8'd25,  32'hDEAD_BEEF}
  };

  // empty text means the row is checked against the predictor
  string dir_text [DIR_ROWS] = '{
    "0", "4294967295", "9", "",
    "FFFFFFFF", "89ABCDEF", "0",
    "ffffffff", "face",
    "000000000000000000000000", "000000000000004294967295",
    "", "",
    "0", "5",
    "4294967295", "0000000042",
    " 4294967295",
    "00000001",
    ""
  };

  unsigned_to_ascii_formatter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected text of one value under the shadow format
  function automatic void format_value(input logic [VAL_W-1:0] v);
    logic [CHAR_W-1:0] digs [MAX_CHARS];
    logic [VAL_W-1:0]  num;
    logic [CHAR_W-1:0] letter;
    logic [CHAR_W-1:0] padc;
    int unsigned       base, r, nd, width, total, npad, k;
    text_beat_t        b;
    base   = fmt.hex_mode ? 16 : 10;
    letter = fmt.upper_case ? CH_UA : CH_LA;
    padc   = fmt.zero_pad ? CH_ZERO : CH_SPACE;
    width  = (fmt.pad_width > MAX_CHARS) ? MAX_CHARS : fmt.pad_width;
    num    = v;
    nd     = 0;
    // digits come out least significant first
    do begin
      r = num % base;
      digs[nd] = (r > 9) ? letter + CHAR_W'(r - 10) : CH_ZERO + CHAR_W'(r);
      nd++;
      num = num / base;
    end while (num != 0 && nd < MAX_CHARS);
    total = (nd > width) ? nd : width;
    npad  = total - nd;
    for (k = 0; k < total; k++) begin
      b.ch   = (k < npad) ? padc : digs[nd - 1 - (k - npad)];
      b.last = (k + 1 == total);
      pending_chars.push_back(b);
    end
  endfunction

  // register data with random junk above the used bits
  function automatic logic [CDATA_W-1:0] with_junk(input logic [CDATA_W-1:0] v,
                                                   input int nbits);
    logic [CDATA_W-1:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? CDATA_W'($urandom) : '0;
    with_junk = (junk & ~((CDATA_W'(1) << nbits) - 1)) | v;
  endfunction

  // random value, biased toward digit-count edges
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] p;
    int               k, n;
    case ($urandom_range(0, 9))
      0: pick_value = '0;
      1: pick_value = '1;
      2: pick_value = VAL_W'($urandom_range(0, 15));
      3: pick_value = VAL_W'($urandom) >> $urandom_range(0, 31);
      4: pick_value = VAL_W'(1) << $urandom_range(0, 31);
      5: begin
        n = $urandom_range(1, 9);
        p = 1;
        for (k = 0; k < n; k++) p = p * 10;
        pick_value = p - VAL_W'($urandom_range(0, 1));
      end
      default: pick_value = VAL_W'($urandom);
    endcase
  endfunction

  // one register beat, shadow updated on acceptance
  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEX_MODE:   fmt.hex_mode   = data[0];
      REG_UPPER_CASE: fmt.upper_case = data[0];
      REG_ZERO_PAD:   fmt.zero_pad   = data[0];
      REG_PAD_WIDTH:  fmt.pad_width  = data[PW_W-1:0];
      default: ;
    endcase
  endtask

  // full register setup once the block has drained, plus a stray index
  task automatic write_config(input logic [CDATA_W-1:0] hd, input logic [CDATA_W-1:0] ud,
                              input logic [CDATA_W-1:0] zd, input logic [CDATA_W-1:0] pd);
    while (pending_chars.size() != 0) @(posedge clk);
    cfg_write(CIDX_W'($urandom_range(REG_PAD_WIDTH + 1, 255)), CDATA_W'($urandom));
    cfg_write(REG_HEX_MODE, hd);
    cfg_write(REG_UPPER_CASE, ud);
    cfg_write(REG_ZERO_PAD, zd);
    cfg_write(REG_PAD_WIDTH, pd);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one value, record its text on acceptance
  task automatic put_value(input logic [VAL_W-1:0] v, input string text);
    text_beat_t b;
    byte        cb;
    int         i;
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    if (text.len() == 0) begin
      format_value(v);
    end else begin
      for (i = 0; i < text.len(); i++) begin
        cb     = text.getc(i);
        b.ch   = cb[CHAR_W-1:0];
        b.last = (i + 1 == text.len());
        pending_chars.push_back(b);
      end
    end
  endtask

  // stimulus: reset, directed rows, random phases, drain
  initial begin
    int                 i, k, plen, burst, sent, phase;
    logic [PW_W-1:0]    w;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    fmt       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed rows
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].wr_cfg) begin
        write_config(dir_rows[i].hex_d, dir_rows[i].up_d, dir_rows[i].zp_d,
                     dir_rows[i].pw_d);
      end
      put_value(dir_rows[i].value, dir_text[i]);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end

    // random phases, each with its own format
    sent  = DIR_ROWS;
    phase = 0;
    while (sent < TOTAL_VALUES) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = PW_W'(MAX_CHARS);
        2:       w = PW_W'($urandom_range(MAX_CHARS + 1, 31));
        3:       w = PW_W'(1);
        default: w = PW_W'($urandom_range(0, MAX_CHARS));
      endcase
      write_config(with_junk(CDATA_W'($urandom_range(0, 1)), 1),
                   with_junk(CDATA_W'($urandom_range(0, 1)), 1),
                   with_junk(CDATA_W'($urandom_range(0, 1)), 1),
                   with_junk(CDATA_W'(w), PW_W));
      // one long receiver hold while values keep coming
      if (phase == 2) hold_req = 1'b1;
      plen  = $urandom_range(8, 40);
      if (plen > TOTAL_VALUES - sent) plen = TOTAL_VALUES - sent;
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      for (k = 0; k < plen; k++) begin
        put_value(pick_value(), "");
        sent++;
        burst--;
        if (burst == 0 || k == plen - 1) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
          burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
      end
      phase++;
    end

    // drain and settle
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver ready pattern, with one long hold on request
  initial begin
    ready_mode_t mode;
    int          seg, n;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      mode = ready_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(4, 60);
      for (n = 0; n < seg; n++) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(posedge clk);
          hold_done = 1'b1;
        end else begin
          case (mode)
            RDY_ALWAYS: out_tready <= 1'b1;
            RDY_RANDOM: out_tready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE: out_tready <= (n % 4 == 0);
            default:    out_tready <= ($urandom_range(0, 9) != 0);
          endcase
        end
      end
    end
  end

  // compare each character beat with the oldest expectation
  always @(posedge clk) begin : check_chars
    text_beat_t b;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char beat, expected none, got tdata %h tlast %b",
                 $time, out_tdata, out_tlast);
      end else begin
        b = pending_chars.pop_front();
        if (out_tdata[CHAR_W-1:0] !== b.ch) begin
          mismatches++;
          $display("%0t: text_char mismatch, expected %h got %h",
                   $time, b.ch, out_tdata[CHAR_W-1:0]);
        end
        if (out_tdata[7] !== 1'b0) begin
          mismatches++;
          $display("%0t: tdata pad bit mismatch, expected 0 got %b", $time, out_tdata[7]);
        end
        if (out_tlast !== b.last) begin
          mismatches++;
          $display("%0t: last_char mismatch, expected %b got %b", $time, b.last, out_tlast);
        end
      end
    end
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ufmt_pkg.sv
src/ufmt_conv.sv
src/ufmt_emit.sv
src/unsigned_to_ascii_formatter_core.sv
tb/testbench.sv
